[rtl/core/sod_pkg.sv]
// Shared constants, types and codes of the stationary object detector.
`default_nettype none

package sod_pkg;

    localparam int ENTRIES     = 16;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int COORD_BITS  = 12;
    localparam int ID_W        = 16;
    localparam int AREA_W      = 2 * COORD_BITS;
    localparam int CTR_W       = COORD_BITS + 2;
    localparam int SQ_W        = 2 * CTR_W;
    localparam int SUM_W       = SQ_W + 1;
    localparam int TIME_W      = 32;

    localparam int AREA_LIM_W  = 24;
    localparam int MOVE_LIM_W  = 12;
    localparam int STOP_W      = 20;
    localparam int LIMSQ_W     = 2 * MOVE_LIM_W;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;

    localparam int CMD_W       = 2;
    localparam int IN_DATA_W   = ID_W + 4 * COORD_BITS;
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [AREA_LIM_W-1:0] AREA_LIM_RST = AREA_LIM_W'(10);
    localparam logic [MOVE_LIM_W-1:0] MOVE_LIM_RST = MOVE_LIM_W'(10);
    localparam logic [STOP_W-1:0]     STOP_RST     = STOP_W'(5000);

    localparam logic [CFG_IDX_W-1:0] REG_AREA_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_LIMIT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TICKS = CFG_IDX_W'(2);

    typedef enum logic [CMD_W-1:0] {
        CMD_DETECT = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_CHECK  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_SQUARE,
        ST_WRITE,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              started;
        logic [TIME_W-1:0] start_time;
        logic [AREA_W-1:0] area;
        logic [CTR_W-1:0]  cx2;
        logic [CTR_W-1:0]  cy2;
    } t_entry;

endpackage

`default_nettype wire

[rtl/core/stationary_object_detector_top.sv]
// A tick advances time as it is accepted; a check raises its result from its report step.
// Detection and check walk the whole object table, one entry per cycle through the table RAM
// read port, and the input is held while they run: a detection until its pick, square and write
// steps are done and a check until its report step passes on; ticks go at one per cycle when idle.
// The result register lets the next item enter while a check result waits; a second check
// holds in its report step until that result leaves. Reset (synchronous, active low) clears
// all valid bits, time and the replace pointer, loads the default limits; RAM is not cleared.
`default_nettype none

module stationary_object_detector_top
    import sod_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // object_id [15:0], box_x [27:16], box_y [39:28], box_width [51:40], box_height [63:52]
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
    // command [1:0]
    input  wire [CMD_W-1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // any_stopped [0], zeros above
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire                    i_cfg_we,
    input  wire [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    // configuration
    logic [AREA_LIM_W-1:0] r_area_lim;
    logic [MOVE_LIM_W-1:0] r_move_lim;
    logic [STOP_W-1:0]     r_stop;

    // control state
    t_state               r_state, n_state;
    logic [ENTRIES-1:0]   r_valid;
    logic [TIME_W-1:0]    r_time;
    logic [IDX_W-1:0]     r_repl;
    logic [IDX_W-1:0]     r_cnt;
    logic                 r_issue_done;
    logic                 r_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx;
    logic                 r_is_check;
    logic                 r_hit;
    logic                 r_any;
    logic                 r_out_vld;
    logic                 r_out_any;

    // item payload and working values
    logic [ID_W-1:0]      r_id;
    logic [AREA_W-1:0]    r_area;
    logic [CTR_W-1:0]     r_cx2;
    logic [CTR_W-1:0]     r_cy2;
    logic [IDX_W-1:0]     r_slot;
    t_entry               r_ent;
    logic [SQ_W-1:0]      r_dxsq;
    logic [SQ_W-1:0]      r_dysq;
    logic [LIMSQ_W-1:0]   r_limsq;
    logic                 r_da_ok;

    // table RAM
    t_entry               mem [ENTRIES];
    t_entry               r_rd_data;

    // combinational
    logic                 in_acc;
    t_cmd                 in_cmd;
    logic                 issue_rd;
    logic                 load_out;
    logic                 do_write;
    logic [IDX_W-1:0]     free_idx;
    logic                 free_found;
    logic [CTR_W-1:0]     dx;
    logic [CTR_W-1:0]     dy;
    logic [AREA_W-1:0]    da;
    logic [SUM_W-1:0]     dist_sq;
    logic [SUM_W-1:0]     lim_sq4;
    logic                 still;
    t_entry               n_entry;
    t_entry               fresh;
    logic [TIME_W-1:0]    elapsed;

    wire [ID_W-1:0]       in_id = s_axis_tdata[ID_W-1:0];
    wire [COORD_BITS-1:0] in_x  = s_axis_tdata[ID_W +: COORD_BITS];
    wire [COORD_BITS-1:0] in_y  = s_axis_tdata[ID_W + COORD_BITS +: COORD_BITS];
    wire [COORD_BITS-1:0] in_w  = s_axis_tdata[ID_W + 2*COORD_BITS +: COORD_BITS];
    wire [COORD_BITS-1:0] in_h  = s_axis_tdata[ID_W + 3*COORD_BITS +: COORD_BITS];

    assign in_cmd = t_cmd'(s_axis_tuser);
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // ---------------- state machine ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (in_cmd == CMD_DETECT || in_cmd == CMD_CHECK)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_vld && r_rd_idx == IDX_LAST) begin
                    n_state = r_is_check ? ST_REPORT : ST_PICK;
                end
            end
            ST_PICK:   n_state = ST_SQUARE;
            ST_SQUARE: n_state = ST_WRITE;
            ST_WRITE:  n_state = ST_IDLE;
            ST_REPORT: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        issue_rd      = (r_state == ST_SCAN) && !r_issue_done;
        load_out      = (r_state == ST_REPORT) && (!r_out_vld || m_axis_tready);
        do_write      = (r_state == ST_WRITE);
    end

    // ---------------- lookup helpers ----------------
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb begin
        fresh            = '0;
        fresh.id         = r_id;
        fresh.start_time = r_time;
    end

    assign elapsed = r_time - r_rd_data.start_time;

    assign dx = (r_cx2 >= r_ent.cx2) ? r_cx2 - r_ent.cx2 : r_ent.cx2 - r_cx2;
    assign dy = (r_cy2 >= r_ent.cy2) ? r_cy2 - r_ent.cy2 : r_ent.cy2 - r_cy2;
    assign da = (r_area >= r_ent.area) ? r_area - r_ent.area : r_ent.area - r_area;

    assign dist_sq = SUM_W'(r_dxsq) + SUM_W'(r_dysq);
    assign lim_sq4 = SUM_W'({r_limsq, 2'b00});
    assign still   = r_da_ok && (dist_sq < lim_sq4);

    always_comb begin
        n_entry      = r_ent;
        n_entry.area = r_area;
        n_entry.cx2  = r_cx2;
        n_entry.cy2  = r_cy2;
        if (still) begin
            if (!r_ent.started) begin
                n_entry.started    = 1'b1;
                n_entry.start_time = r_time;
            end
        end else begin
            n_entry.started = 1'b0;
        end
    end

    // ---------------- table RAM ----------------
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            mem[r_slot] <= n_entry;
        end
        r_rd_data <= mem[r_cnt];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_area_lim   <= AREA_LIM_RST;
            r_move_lim   <= MOVE_LIM_RST;
            r_stop       <= STOP_RST;
            r_valid      <= '0;
            r_time       <= '0;
            r_repl       <= '0;
            r_cnt        <= '0;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_rd_idx     <= '0;
            r_is_check   <= 1'b0;
            r_hit        <= 1'b0;
            r_any        <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == REG_AREA_LIMIT) begin
                    r_area_lim <= i_cfg_data[AREA_LIM_W-1:0];
                end
                if (i_cfg_idx == REG_MOVE_LIMIT) begin
                    r_move_lim <= i_cfg_data[MOVE_LIM_W-1:0];
                end
                if (i_cfg_idx == REG_STOP_TICKS) begin
                    r_stop <= i_cfg_data[STOP_W-1:0];
                end
            end

            if (in_acc) begin
                if (in_cmd == CMD_TICK) begin
                    r_time <= r_time + 1'b1;
                end
                r_is_check   <= (in_cmd == CMD_CHECK);
                r_cnt        <= '0;
                r_issue_done <= 1'b0;
                r_hit        <= 1'b0;
                r_any        <= 1'b0;
            end

            // walk the table, one read per cycle
            r_rd_vld <= issue_rd;
            r_rd_idx <= r_cnt;
            if (issue_rd) begin
                if (r_cnt == IDX_LAST) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end

            if (r_state == ST_SCAN && r_rd_vld && r_valid[r_rd_idx]) begin
                if (!r_is_check && !r_hit && r_rd_data.id == r_id) begin
                    r_hit <= 1'b1;
                end
                if (r_is_check && r_rd_data.started && elapsed >= TIME_W'(r_stop)) begin
                    r_any <= 1'b1;
                end
            end

            // table full and id missing: advance the round-robin victim
            if (r_state == ST_PICK && !r_hit && !free_found) begin
                r_repl <= (r_repl == IDX_LAST) ? '0 : r_repl + 1'b1;
            end

            if (do_write) begin
                r_valid[r_slot] <= 1'b1;
            end

            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_id   <= in_id;
            r_area <= AREA_W'(in_w) * AREA_W'(in_h);
            r_cx2  <= CTR_W'({in_x, 1'b0}) + CTR_W'(in_w);
            r_cy2  <= CTR_W'({in_y, 1'b0}) + CTR_W'(in_h);
        end

        if (r_state == ST_SCAN && r_rd_vld && !r_is_check && !r_hit &&
            r_valid[r_rd_idx] && r_rd_data.id == r_id) begin
            r_slot <= r_rd_idx;
            r_ent  <= r_rd_data;
        end

        if (r_state == ST_PICK && !r_hit) begin
            r_slot <= free_found ? free_idx : r_repl;
            r_ent  <= fresh;
        end

        if (r_state == ST_SQUARE) begin
            r_dxsq  <= SQ_W'(dx) * SQ_W'(dx);
            r_dysq  <= SQ_W'(dy) * SQ_W'(dy);
            r_limsq <= LIMSQ_W'(r_move_lim) * LIMSQ_W'(r_move_lim);
            r_da_ok <= da < r_area_lim;
        end

        if (load_out) begin
            r_out_any <= r_any;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 1){1'b0}}, r_out_any};

    // ---------------- assertions ----------------
    a_rd_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == ST_SCAN))
        else $error("table read data returned outside a scan");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> r_valid[$past(r_slot)])
        else $error("written entry not marked valid");

    a_repl_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_repl)) |->
            ($past(r_state == ST_PICK) && $past(&r_valid)))
        else $error("replace pointer moved while the table had a free entry");

    a_time_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_time)) |->
            $past(in_acc && in_cmd == CMD_TICK))
        else $error("time advanced without a tick item");

    a_result_from_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_vld)) |-> $past(r_state == ST_REPORT))
        else $error("result raised outside the report state");

endmodule

`default_nettype wire
